// File: rtl/core/csob_pkg.sv
`default_nettype none
package csob_pkg;

   localparam int unsigned CH_W   = 8;
   localparam int unsigned POS_W  = 17;
   localparam int unsigned SIDE_W = 16;
   localparam int unsigned DEN_W  = 16;
   localparam int unsigned NUM_W  = 24;
   localparam int unsigned LANES  = 3;

   // restoring division, one quotient bit per step
   localparam int unsigned DIV_STEPS       = CH_W;
   localparam int unsigned STEPS_PER_STAGE = 2;
   localparam int unsigned DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 2'd1;

   localparam logic [SIDE_W-1:0] SIDE_RESET = 16'd65535;

   localparam logic [CH_W-1:0] CH_MAX   = 8'd255;
   localparam logic [NUM_W-1:0] A_ROUND = 24'd127;

   // lane order inside the divider
   localparam int unsigned LANE_RED   = 0;
   localparam int unsigned LANE_GREEN = 1;
   localparam int unsigned LANE_BLUE  = 2;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic      write_en;
      logic      bypass;
      pixel_type pix;
   } side_type;

   typedef struct packed {
      side_type                          side;
      logic [LANES-1:0][NUM_W-1:0]       rem;
      logic [LANES-1:0][DEN_W-1:0]       den;
      logic [LANES-1:0][CH_W-1:0]        quot;
   } div_item_type;

endpackage
`default_nettype wire

// File: rtl/core/clipped_source_over_blend_top.sv
`default_nettype none
// channel  | handshake             | payload
// req      | req_valid/req_ready   | src and dst rgba, pos_x, pos_y
// rsp      | rsp_valid/rsp_ready   | rsp_out_red..rsp_out_alpha, rsp_write_enable
// csr      | csr_wr_en             | csr_index, csr_wdata (canvas width, height)
//
// one beat per clock sustained while rsp_ready stays high; two front stages
// (clip and products, sums and alpha), four divider stages of two quotient
// bits each, one output register.
// reset clears the valid bits and sets both canvas sides to 65535.
// each stage holds its beat while the next is full, so bubbles are squeezed out.
module clipped_source_over_blend_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire [csob_pkg::CH_W-1:0]             req_src_red,
   input  wire [csob_pkg::CH_W-1:0]             req_src_green,
   input  wire [csob_pkg::CH_W-1:0]             req_src_blue,
   input  wire [csob_pkg::CH_W-1:0]             req_src_alpha,
   input  wire [csob_pkg::CH_W-1:0]             req_dst_red,
   input  wire [csob_pkg::CH_W-1:0]             req_dst_green,
   input  wire [csob_pkg::CH_W-1:0]             req_dst_blue,
   input  wire [csob_pkg::CH_W-1:0]             req_dst_alpha,
   input  wire signed [csob_pkg::POS_W-1:0]     req_pos_x,
   input  wire signed [csob_pkg::POS_W-1:0]     req_pos_y,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [csob_pkg::CH_W-1:0]            rsp_out_red,
   output logic [csob_pkg::CH_W-1:0]            rsp_out_green,
   output logic [csob_pkg::CH_W-1:0]            rsp_out_blue,
   output logic [csob_pkg::CH_W-1:0]            rsp_out_alpha,
   output logic                                 rsp_write_enable,
   input  wire                                  csr_wr_en,
   input  wire [csob_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [csob_pkg::SIDE_W-1:0]           csr_wdata
);

   logic [csob_pkg::SIDE_W-1:0] canvas_width_ff, canvas_height_ff;

   csob_pkg::pixel_type src, dst;

   logic                   stg_valid [csob_pkg::DIV_STAGES+1];
   logic                   stg_ready [csob_pkg::DIV_STAGES+1];
   csob_pkg::div_item_type stg_item  [csob_pkg::DIV_STAGES+1];

   logic                      o_valid_ff;
   csob_pkg::pixel_type       o_pix_ff, o_pix_in;
   logic                      o_we_ff;
   logic                      o_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= csob_pkg::SIDE_RESET;
         canvas_height_ff <= csob_pkg::SIDE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            csob_pkg::CSR_CANVAS_WIDTH:  canvas_width_ff  <= csr_wdata;
            csob_pkg::CSR_CANVAS_HEIGHT: canvas_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign src = '{red: req_src_red, green: req_src_green, blue: req_src_blue,
                  alpha: req_src_alpha};
   assign dst = '{red: req_dst_red, green: req_dst_green, blue: req_dst_blue,
                  alpha: req_dst_alpha};

   csob_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .src           (src),
      .dst           (dst),
      .pos_x         (req_pos_x),
      .pos_y         (req_pos_y),
      .canvas_width  (canvas_width_ff),
      .canvas_height (canvas_height_ff),
      .out_valid     (stg_valid[0]),
      .out_ready     (stg_ready[0]),
      .out_item      (stg_item[0])
   );

   for (genvar i = 0; i < csob_pkg::DIV_STAGES; i++) begin : g_div
      csob_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_item   (stg_item[i]),
         .out_valid (stg_valid[i+1]),
         .out_ready (stg_ready[i+1]),
         .out_item  (stg_item[i+1])
      );
   end

   assign o_ready = !o_valid_ff || rsp_ready;
   assign stg_ready[csob_pkg::DIV_STAGES] = o_ready;

   always_comb begin
      csob_pkg::div_item_type last;
      last = stg_item[csob_pkg::DIV_STAGES];
      if (last.side.bypass) begin
         o_pix_in = last.side.pix;
      end else begin
         o_pix_in.red   = last.quot[csob_pkg::LANE_RED];
         o_pix_in.green = last.quot[csob_pkg::LANE_GREEN];
         o_pix_in.blue  = last.quot[csob_pkg::LANE_BLUE];
         // blended alpha rides beside the divider
         o_pix_in.alpha = last.side.pix.alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= stg_valid[csob_pkg::DIV_STAGES];
      end
      if (o_ready && stg_valid[csob_pkg::DIV_STAGES]) begin
         o_pix_ff <= o_pix_in;
         o_we_ff  <= stg_item[csob_pkg::DIV_STAGES].side.write_en;
      end
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_out_red      = o_pix_ff.red;
   assign rsp_out_green    = o_pix_ff.green;
   assign rsp_out_blue     = o_pix_ff.blue;
   assign rsp_out_alpha    = o_pix_ff.alpha;
   assign rsp_write_enable = o_we_ff;

endmodule
`default_nettype wire

// File: rtl/core/csob_front.sv
`default_nettype none
module csob_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  csob_pkg::pixel_type              src,
   input  csob_pkg::pixel_type              dst,
   input  wire signed [csob_pkg::POS_W-1:0] pos_x,
   input  wire signed [csob_pkg::POS_W-1:0] pos_y,
   input  wire [csob_pkg::SIDE_W-1:0]       canvas_width,
   input  wire [csob_pkg::SIDE_W-1:0]       canvas_height,
   output logic                             out_valid,
   input  wire                              out_ready,
   output csob_pkg::div_item_type           out_item
);

   // stage a: clip, copy decision, first products
   logic                         a_valid_ff;
   csob_pkg::side_type           a_side_ff, a_side_in;
   logic [2:0][15:0]             a_sprod_ff, a_sprod_in;
   logic [2:0][csob_pkg::CH_W-1:0] a_dc_ff, a_dc_in;
   logic [15:0]                  a_dab_ff, a_dab_in;
   logic [15:0]                  a_sa255_ff, a_sa255_in;
   logic                         a_ready;

   // stage b: numerators, denominators and blended alpha
   logic                         b_valid_ff;
   csob_pkg::div_item_type       b_item_ff, b_item_in;
   logic                         b_ready;

   logic on_canvas, write_en, copy_src;
   logic [csob_pkg::CH_W-1:0] sa, da;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      sa = src.alpha;
      da = dst.alpha;
      // a negative coordinate has its sign bit set, the rest fits 16 bits
      on_canvas = !pos_x[csob_pkg::POS_W-1] && !pos_y[csob_pkg::POS_W-1]
         && (pos_x[csob_pkg::SIDE_W-1:0] < canvas_width)
         && (pos_y[csob_pkg::SIDE_W-1:0] < canvas_height);
      write_en = on_canvas && (sa != '0);
      copy_src = (sa == csob_pkg::CH_MAX) || (da == '0);
      a_side_in.write_en = write_en;
      a_side_in.bypass   = !write_en || copy_src;
      a_side_in.pix      = write_en ? src : dst;
      a_sprod_in[0] = 16'(src.red) * 16'(sa);
      a_sprod_in[1] = 16'(src.green) * 16'(sa);
      a_sprod_in[2] = 16'(src.blue) * 16'(sa);
      a_dc_in[0] = dst.red;
      a_dc_in[1] = dst.green;
      a_dc_in[2] = dst.blue;
      a_dab_in   = 16'(da) * 16'(csob_pkg::CH_MAX - sa);
      a_sa255_in = {sa, 8'd0} - 16'(sa);
   end

   always_comb begin
      logic [15:0] ra;
      logic [15:0] alpha_num, alpha_sum;
      logic [csob_pkg::NUM_W-1:0] s_term, d_term;
      ra = a_sa255_ff + a_dab_ff;
      // x / 255 as (x + (x >> 8) + 1) >> 8, exact while the quotient stays at most 255
      alpha_num = ra + csob_pkg::DEN_W'(csob_pkg::A_ROUND);
      alpha_sum = alpha_num + {8'd0, alpha_num[15:8]} + 16'd1;
      b_item_in.side = a_side_ff;
      if (!a_side_ff.bypass) b_item_in.side.pix.alpha = alpha_sum[15:8];
      b_item_in.quot = '0;
      for (int i = 0; i < csob_pkg::LANES; i++) begin
         s_term = {a_sprod_ff[i], 8'd0} - csob_pkg::NUM_W'(a_sprod_ff[i]);
         d_term = csob_pkg::NUM_W'(a_dc_ff[i]) * csob_pkg::NUM_W'(a_dab_ff);
         b_item_in.rem[i] = s_term + d_term + csob_pkg::NUM_W'(ra[15:1]);
         b_item_in.den[i] = ra;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
      if (a_ready && in_valid) begin
         a_side_ff  <= a_side_in;
         a_sprod_ff <= a_sprod_in;
         a_dc_ff    <= a_dc_in;
         a_dab_ff   <= a_dab_in;
         a_sa255_ff <= a_sa255_in;
      end
      if (b_ready && a_valid_ff) b_item_ff <= b_item_in;
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule
`default_nettype wire

// File: rtl/core/csob_div_stage.sv
`default_nettype none
module csob_div_stage (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  csob_pkg::div_item_type in_item,
   output logic                   out_valid,
   input  wire                    out_ready,
   output csob_pkg::div_item_type out_item
);

   logic                   valid_ff;
   csob_pkg::div_item_type item_ff, item_in;

   assign in_ready = !valid_ff || out_ready;

   // remainder stays below den << 8; compare against den << 7, then shift left
   always_comb begin
      logic [csob_pkg::NUM_W-1:0] rem, top;
      logic [csob_pkg::CH_W-1:0]  q;
      item_in = in_item;
      for (int l = 0; l < csob_pkg::LANES; l++) begin
         rem = in_item.rem[l];
         q   = in_item.quot[l];
         top = csob_pkg::NUM_W'({in_item.den[l], 7'd0});
         for (int s = 0; s < csob_pkg::STEPS_PER_STAGE; s++) begin
            if (rem >= top) begin
               rem = rem - top;
               q   = {q[csob_pkg::CH_W-2:0], 1'b1};
            end else begin
               q   = {q[csob_pkg::CH_W-2:0], 1'b0};
            end
            rem = {rem[csob_pkg::NUM_W-2:0], 1'b0};
         end
         item_in.rem[l]  = rem;
         item_in.quot[l] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
module tb_top;
   import csob_pkg::*;

   localparam int PIPE_DEPTH  = 7;
   localparam int STUCK_LIMIT = 2000;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      pixel_type               src;
      pixel_type               dst;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
   } pixel_beat_t;

   typedef struct packed {
      pixel_type pix;
      logic      write_en;
   } blend_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [CH_W-1:0]         req_src_red = '0;
   logic [CH_W-1:0]         req_src_green = '0;
   logic [CH_W-1:0]         req_src_blue = '0;
   logic [CH_W-1:0]         req_src_alpha = '0;
   logic [CH_W-1:0]         req_dst_red = '0;
   logic [CH_W-1:0]         req_dst_green = '0;
   logic [CH_W-1:0]         req_dst_blue = '0;
   logic [CH_W-1:0]         req_dst_alpha = '0;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;

   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [CH_W-1:0] rsp_out_red;
   logic [CH_W-1:0] rsp_out_green;
   logic [CH_W-1:0] rsp_out_blue;
   logic [CH_W-1:0] rsp_out_alpha;
   logic            rsp_write_enable;

   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CANVAS_WIDTH;
   logic [SIDE_W-1:0]    csr_wdata = '0;

   // local copy of the canvas registers
   int canvas_w = SIDE_RESET;
   int canvas_h = SIDE_RESET;

   blend_result_t composited_q[$];
   int error_count = 0;
   int stuck_cycles = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit req_busy = 1'b0;

   always #4 clock = ~clock;

   clipped_source_over_blend_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_red      (req_src_red),
      .req_src_green    (req_src_green),
      .req_src_blue     (req_src_blue),
      .req_src_alpha    (req_src_alpha),
      .req_dst_red      (req_dst_red),
      .req_dst_green    (req_dst_green),
      .req_dst_blue     (req_dst_blue),
      .req_dst_alpha    (req_dst_alpha),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_write_enable (rsp_write_enable),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   function automatic logic [CH_W-1:0] mix_channel(input int unsigned s, input int unsigned d,
                                                   input int unsigned sa, input int unsigned da,
                                                   input int unsigned ra);
      return CH_W'((s * sa * CH_MAX + d * da * (CH_MAX - sa) + ra / 2) / ra);
   endfunction

   function automatic blend_result_t composite_pixel(input pixel_beat_t b);
      blend_result_t res;
      int xi;
      int yi;
      int unsigned sa;
      int unsigned da;
      int unsigned ra;
      xi = $signed(b.pos_x);
      yi = $signed(b.pos_y);
      sa = b.src.alpha;
      da = b.dst.alpha;
      res.pix = b.dst;
      res.write_en = xi >= 0 && yi >= 0 && xi < canvas_w && yi < canvas_h && sa != 0;
      if (res.write_en) begin
         if (sa == CH_MAX || da == 0) begin
            res.pix = b.src;
         end else begin
            ra = sa * CH_MAX + da * (CH_MAX - sa);
            res.pix.red   = mix_channel(b.src.red, b.dst.red, sa, da, ra);
            res.pix.green = mix_channel(b.src.green, b.dst.green, sa, da, ra);
            res.pix.blue  = mix_channel(b.src.blue, b.dst.blue, sa, da, ra);
            res.pix.alpha = CH_W'((ra + A_ROUND) / CH_MAX);
         end
      end
      return res;
   endfunction

   // result side: check each beat, then pick the next ready value
   always @(posedge clock) begin
      blend_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (composited_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("mismatch: unexpected result rgba %h %h %h %h we %b",
                        rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha,
                        rsp_write_enable);
         end else begin
            want = composited_q.pop_front();
            if (rsp_out_red !== want.pix.red || rsp_out_green !== want.pix.green ||
                rsp_out_blue !== want.pix.blue || rsp_out_alpha !== want.pix.alpha ||
                rsp_write_enable !== want.write_en) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected rgba %h %h %h %h we %b, got %h %h %h %h we %b",
                           want.pix.red, want.pix.green, want.pix.blue, want.pix.alpha,
                           want.write_en, rsp_out_red, rsp_out_green, rsp_out_blue,
                           rsp_out_alpha, rsp_write_enable);
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic release_req();
      if (req_busy) begin
         req_valid <= 1'b0;
         req_busy = 1'b0;
      end
   endtask

   task automatic send_pixel(input pixel_type src, input pixel_type dst,
                             input int x, input int y);
      pixel_beat_t beat;
      int gap;
      beat.src = src;
      beat.dst = dst;
      beat.pos_x = POS_W'(x);
      beat.pos_y = POS_W'(y);
      gap = 0;
      while ($urandom_range(99) < req_idle_pct)
         gap++;
      if (gap > 0) begin
         release_req();
         repeat (gap) @(posedge clock);
      end
      req_src_red   <= src.red;
      req_src_green <= src.green;
      req_src_blue  <= src.blue;
      req_src_alpha <= src.alpha;
      req_dst_red   <= dst.red;
      req_dst_green <= dst.green;
      req_dst_blue  <= dst.blue;
      req_dst_alpha <= dst.alpha;
      req_pos_x     <= beat.pos_x;
      req_pos_y     <= beat.pos_y;
      req_valid     <= 1'b1;
      req_busy = 1'b1;
      do @(posedge clock); while (!req_ready);
      composited_q.push_back(composite_pixel(beat));
   endtask

   task automatic drain_results();
      release_req();
      while (composited_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIDE_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_CANVAS_WIDTH)
         canvas_w = value;
      else if (idx == CSR_CANVAS_HEIGHT)
         canvas_h = value;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_canvas(input int w, input int h);
      drain_results();
      write_csr(CSR_CANVAS_WIDTH, SIDE_W'(w));
      write_csr(CSR_CANVAS_HEIGHT, SIDE_W'(h));
   endtask

   function automatic pixel_type rand_pixel();
      pixel_type p;
      p = $urandom;
      case ($urandom_range(9))
         0: p.alpha = '0;
         1: p.alpha = CH_MAX;
         2: p.alpha = $urandom_range(1) ? 8'd1 : 8'd254;
         default: ;
      endcase
      return p;
   endfunction

   // mostly around the canvas, some anywhere in the 17-bit range
   function automatic int rand_coord(input int side);
      logic signed [POS_W-1:0] raw;
      int c;
      case ($urandom_range(9))
         0, 1: begin
            raw = POS_W'($urandom);
            c = raw;
         end
         2: begin
            case ($urandom_range(3))
               0: c = -1;
               1: c = 0;
               2: c = side - 1;
               default: c = side;
            endcase
         end
         default: c = int'($urandom_range(side + 5)) - 3;
      endcase
      return c;
   endfunction

   task automatic test_directed_blend();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      // transparent source is never written
      send_pixel(32'h0000_0000, 32'h1122_3344, 0, 0);
      send_pixel(32'hFFFF_FF00, 32'hFFFF_FFFF, 5, 5);
      // opaque source and empty destination copy
      send_pixel(32'h1234_56FF, 32'hABCD_EF80, 0, 0);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000, 65534, 65534);
      send_pixel(32'h8080_8080, 32'h4040_4000, 3, 7);
      // true blends
      send_pixel(32'hFF00_0001, 32'h00FF_0001, 1, 1);
      send_pixel(32'h00FF_00FE, 32'hFF00_FFFF, 2, 2);
      send_pixel(32'hFFFF_FF80, 32'h0000_0080, 10, 20);
      send_pixel(32'h0000_0001, 32'hFFFF_FFFF, 100, 100);
      send_pixel(32'hFFFF_FFFE, 32'hFFFF_FFFF, 7, 7);
      send_pixel(32'h5AA5_3C7F, 32'hC33C_9601, 40000, 12345);
      // off the canvas
      send_pixel(32'hFFFF_FFFF, 32'h5555_5555, -1, 0);
      send_pixel(32'hFFFF_FFFF, 32'h5555_5555, 0, -1);
      send_pixel(32'hFFFF_FFFF, 32'hAAAA_AAAA, -65536, -65536);
      send_pixel(32'h1234_5678, 32'h8765_4321, 65535, 0);
      send_pixel(32'h1234_5678, 32'h8765_4321, 0, 65535);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 65535, 65535);
      drain_results();
   endtask

   task automatic test_canvas_clip();
      set_canvas(1, 1);
      send_pixel(32'h10203040, 32'h50607080, 0, 0);
      send_pixel(32'h10203040, 32'h50607080, 1, 0);
      send_pixel(32'h10203040, 32'h50607080, 0, 1);
      send_pixel(32'h10203040, 32'h50607080, -1, -1);
      send_pixel(32'hA0B0C0FF, 32'h50607080, 0, 0);
      // a zero side puts everything off the canvas
      set_canvas(0, 65535);
      send_pixel(32'hA0B0C0FF, 32'h50607080, 0, 0);
      set_canvas(65535, 0);
      send_pixel(32'hA0B0C0FF, 32'h50607080, 0, 0);
      drain_results();
   endtask

   task automatic test_unknown_index();
      set_canvas(4, 4);
      write_csr(CSR_SPARE_2, '0);
      write_csr(CSR_SPARE_3, '1);
      send_pixel(32'h3366_99C0, 32'hCC99_6640, 3, 3);
      send_pixel(32'h3366_99C0, 32'hCC99_6640, 4, 0);
      send_pixel(32'h3366_99C0, 32'hCC99_6640, 0, 4);
      drain_results();
   endtask

   task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct,
                                      input int w, input int h);
      set_canvas(w, h);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (items)
         send_pixel(rand_pixel(), rand_pixel(), rand_coord(w), rand_coord(h));
      drain_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_blend();
      test_canvas_clip();
      test_unknown_index();
      test_random_traffic(200, 0, 0, 65535, 65535);
      test_random_traffic(200, 54, 0, 200, 150);
      test_random_traffic(200, 0, 54, 1, 65535);
      test_random_traffic(200, 36, 36, 65535, 1);
      test_random_traffic(200, 0, 0, $urandom_range(1000, 1), $urandom_range(1000, 1));
      test_random_traffic(200, 54, 0, 0, 40);
      test_random_traffic(200, 0, 54, 64, 64);
      test_random_traffic(200, 36, 36, 65535, 65535);
      drain_results();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
`default_nettype wire
